### design/afd_pkg.sv
package afd_pkg;

    localparam int WIN_LEN   = 11;
    localparam int WIN_W     = 8 * WIN_LEN;
    localparam int MIN_FRAME = 20;
    localparam int LEN_MAX   = 255;

    // Markers; the last character sits in the low byte (newest byte of the window).
    localparam logic [WIN_W-1:0] PAT_NATIVE      = "/STARTDATA/";
    localparam logic [63:0]      PAT_CONNECT     = "CONNECT/";
    localparam logic [39:0]      PAT_PING        = "PING/";
    localparam logic [71:0]      PAT_DATA_END    = "/ENDDATA/";
    localparam logic [71:0]      PAT_FOREIGN_END = "/NO DATA/";

    typedef enum logic [2:0] {
        EV_NONE          = 3'd0,
        EV_NATIVE_START  = 3'd1,
        EV_FOREIGN_START = 3'd2,
        EV_DATA_END      = 3'd3,
        EV_FOREIGN_END   = 3'd4,
        EV_DROP          = 3'd5
    } t_event;

    typedef struct packed {
        logic       valid;
        logic [7:0] rx_byte;
    } t_byte_req;

    typedef struct packed {
        t_event     event_res;
        logic [7:0] frame_length;
    } t_result;

endpackage

### design/afd_if.sv
interface afd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface afd_out_if;
    logic       valid;
    logic       ready;
    logic [2:0] event_res;
    logic [7:0] frame_length;

    modport source (output valid, output event_res, output frame_length, input ready);
    modport sink   (input valid, input event_res, input frame_length, output ready);
endinterface

### design/afd_in_stage.sv
module afd_in_stage (
    input  logic                i_clk,
    input  logic                i_rst_n,
    afd_in_if.sink              i_rx,
    input  logic                i_advance,
    output afd_pkg::t_byte_req  o_req
);

    logic       r_valid;
    logic [7:0] r_byte;

    // Room when empty, or when the held byte moves on this cycle.
    assign i_rx.ready = !r_valid || i_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_rx.ready) begin
            r_valid <= i_rx.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rx.valid && i_rx.ready) begin
            r_byte <= i_rx.rx_byte;
        end
    end

    assign o_req.valid   = r_valid;
    assign o_req.rx_byte = r_byte;

endmodule

### design/afd_tracker.sv
module afd_tracker #(
    parameter int BUF_BYTES = 256
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  afd_pkg::t_byte_req  i_req,
    input  logic                i_advance,
    output afd_pkg::t_result    o_result
);

    localparam int CNT_W = $clog2(BUF_BYTES);
    localparam int EXT_W = (CNT_W > 8) ? CNT_W : 8;

    logic [afd_pkg::WIN_W-1:0] r_win;
    logic [afd_pkg::WIN_W-1:0] n_win;
    logic [CNT_W-1:0]          r_cnt;
    logic [CNT_W-1:0]          n_cnt;
    logic                      r_collecting;
    logic                      n_collecting;

    logic [CNT_W-1:0]          w_cnt_inc;
    logic [EXT_W-1:0]          w_cnt_ext;
    logic [7:0]                w_len_sat;
    logic                      w_hunt_again;
    afd_pkg::t_event           w_event;
    logic [7:0]                w_len;

    // A collecting count never passes BUF_BYTES-1, so the increment cannot wrap.
    assign w_cnt_inc = r_cnt + 1'b1;
    assign w_cnt_ext = EXT_W'(w_cnt_inc);
    assign w_len_sat = (w_cnt_ext > EXT_W'(afd_pkg::LEN_MAX)) ? 8'(afd_pkg::LEN_MAX)
                                                             : w_cnt_ext[7:0];

    always_comb begin
        n_win        = {r_win[afd_pkg::WIN_W-9:0], i_req.rx_byte};
        n_cnt        = r_cnt;
        n_collecting = r_collecting;
        w_event      = afd_pkg::EV_NONE;
        w_len        = '0;
        w_hunt_again = 1'b0;

        if (!r_collecting) begin
            // hunting: count saturates at the window length
            if (r_cnt < CNT_W'(afd_pkg::WIN_LEN)) begin
                n_cnt = w_cnt_inc;
            end
            if (n_win == afd_pkg::PAT_NATIVE) begin
                n_collecting = 1'b1;
                w_event      = afd_pkg::EV_NATIVE_START;
            end else if (n_win[63:0] == afd_pkg::PAT_CONNECT ||
                         n_win[39:0] == afd_pkg::PAT_PING) begin
                n_collecting = 1'b1;
                w_event      = afd_pkg::EV_FOREIGN_START;
            end
        end else begin
            n_cnt = w_cnt_inc;
            if (w_cnt_inc >= CNT_W'(afd_pkg::MIN_FRAME)) begin
                priority if (w_cnt_inc == CNT_W'(BUF_BYTES - 1)) begin
                    w_event      = afd_pkg::EV_DROP;
                    w_hunt_again = 1'b1;
                end else if (n_win[71:0] == afd_pkg::PAT_DATA_END) begin
                    w_event      = afd_pkg::EV_DATA_END;
                    w_len        = w_len_sat;
                    w_hunt_again = 1'b1;
                end else if (n_win[71:0] == afd_pkg::PAT_FOREIGN_END) begin
                    w_event      = afd_pkg::EV_FOREIGN_END;
                    w_len        = w_len_sat;
                    w_hunt_again = 1'b1;
                end else begin
                    w_event      = afd_pkg::EV_NONE;
                end
            end
        end

        if (w_hunt_again) begin
            n_win        = '0;
            n_cnt        = '0;
            n_collecting = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win        <= '0;
            r_cnt        <= '0;
            r_collecting <= 1'b0;
        end else if (i_advance) begin
            r_win        <= n_win;
            r_cnt        <= n_cnt;
            r_collecting <= n_collecting;
        end
    end

    assign o_result.event_res    = w_event;
    assign o_result.frame_length = w_len;

endmodule

### design/afd_out_stage.sv
module afd_out_stage (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  afd_pkg::t_byte_req  i_req,
    input  afd_pkg::t_result    i_result,
    afd_out_if.source           o_res,
    output logic                o_advance
);

    logic             r_valid;
    afd_pkg::t_result r_result;

    // Load when the result register is empty or being drained.
    assign o_advance = i_req.valid && (!r_valid || o_res.ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_advance) begin
            r_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_advance) begin
            r_result <= i_result;
        end
    end

    assign o_res.valid        = r_valid;
    assign o_res.event_res    = r_result.event_res;
    assign o_res.frame_length = r_result.frame_length;

endmodule

### design/ascii_frame_delimiter.sv
// Frame finder for an ASCII byte stream. Takes one received byte per request and
// returns one result per byte: an event code (none, native start, foreign start,
// data end, foreign end, overflow drop) and, on the two end events, the frame length
// (the frame is the last frame_length bytes seen, saturating at 255). Throughput is
// one byte per clock while results are taken; an accepted byte waits in the input
// register, then passes the marker compares and count update into the result
// register, where its result is presented. While a result is stalled, one
// more byte can still enter the input register; after that the input waits.
module ascii_frame_delimiter #(
    parameter int BUF_BYTES = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    afd_in_if.sink      i_rx,
    afd_out_if.source   o_res
);

    afd_pkg::t_byte_req w_req;
    afd_pkg::t_result   w_result;
    logic               w_advance;

    afd_in_stage u_in (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rx      (i_rx),
        .i_advance (w_advance),
        .o_req     (w_req)
    );

    afd_tracker #(
        .BUF_BYTES (BUF_BYTES)
    ) u_trk (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (w_req),
        .i_advance (w_advance),
        .o_result  (w_result)
    );

    afd_out_stage u_out (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (w_req),
        .i_result  (w_result),
        .o_res     (o_res),
        .o_advance (w_advance)
    );

`ifndef SYNTHESIS
    a_len_only_on_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.event_res != afd_pkg::EV_DATA_END &&
         o_res.event_res != afd_pkg::EV_FOREIGN_END) |-> (o_res.frame_length == 8'd0))
        else $error("frame_length set on a non-end event");

    a_end_len_min: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && (o_res.event_res == afd_pkg::EV_DATA_END ||
         o_res.event_res == afd_pkg::EV_FOREIGN_END))
        |-> (o_res.frame_length >= 8'(afd_pkg::MIN_FRAME)))
        else $error("frame ended below the minimum length");

    a_full_pipe_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_req.valid && o_res.valid && !o_res.ready) |-> !i_rx.ready)
        else $error("request taken while both stages are held");
`endif

endmodule

### sim/tb_top.sv
module tb_top;

    localparam int BUF_BYTES    = 256;
    localparam int RANDOM_ITEMS = 1350;
    localparam int TIMEOUT      = 2_000_000;

    localparam afd_pkg::t_result NO_EVENT = '{event_res: afd_pkg::EV_NONE,
                                              frame_length: 8'd0};

    typedef struct {
        logic [7:0]       rx_byte;
        bit               typed;
        afd_pkg::t_result res;
    } t_row;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    afd_in_if  rx_if ();
    afd_out_if res_if ();

    ascii_frame_delimiter #(
        .BUF_BYTES (BUF_BYTES)
    ) u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rx    (rx_if),
        .o_res   (res_if)
    );

    always #1 i_clk = ~i_clk;

    // Frame tracker state: window keeps the newest byte in the low byte.
    logic [afd_pkg::WIN_W-1:0] window        = '0;
    int unsigned               frame_count   = 0;
    bit                        in_frame      = 1'b0;
    bit                        foreign_frame = 1'b0;

    afd_pkg::t_result pending_results[$];
    t_row             directed_rows[$];

    string starters[3] = '{"/STARTDATA/", "CONNECT/", "PING/"};
    string enders[2]   = '{"/ENDDATA/", "/NO DATA/"};

    int err_count  = 0;
    int bytes_sent = 0;
    int rx_calm    = 0;
    int res_calm   = 0;
    int res_stall  = 0;

    function automatic afd_pkg::t_result frame_step(logic [7:0] b);
        afd_pkg::t_result r;
        r = NO_EVENT;
        window = {window[afd_pkg::WIN_W-9:0], b};
        if (!in_frame) begin
            if (frame_count < afd_pkg::WIN_LEN) frame_count++;
            if (window == afd_pkg::PAT_NATIVE) begin
                in_frame = 1'b1;
                r.event_res = afd_pkg::EV_NATIVE_START;
            end else if (window[63:0] == afd_pkg::PAT_CONNECT ||
                         window[39:0] == afd_pkg::PAT_PING) begin
                in_frame = 1'b1;
                foreign_frame = 1'b1;
                r.event_res = afd_pkg::EV_FOREIGN_START;
            end
        end else begin
            frame_count++;
            if (frame_count >= afd_pkg::MIN_FRAME) begin
                if (frame_count + 1 < BUF_BYTES) begin
                    if (window[71:0] == afd_pkg::PAT_DATA_END) begin
                        r.event_res = afd_pkg::EV_DATA_END;
                    end else if (window[71:0] == afd_pkg::PAT_FOREIGN_END) begin
                        r.event_res = afd_pkg::EV_FOREIGN_END;
                    end
                    if (r.event_res != afd_pkg::EV_NONE) begin
                        r.frame_length = (frame_count > afd_pkg::LEN_MAX) ?
                                         8'(afd_pkg::LEN_MAX) : 8'(frame_count);
                    end
                end else begin
                    r.event_res = afd_pkg::EV_DROP;
                end
            end
            if (r.event_res != afd_pkg::EV_NONE) begin
                window        = '0;
                frame_count   = 0;
                in_frame      = 1'b0;
                foreign_frame = 1'b0;
            end
        end
        return r;
    endfunction

    // Mostly short gaps, a few long ones, and now and then a calm stretch.
    function automatic int pick_gap(inout int calm);
        int r;
        if (calm > 0) begin
            calm--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 2) begin
            calm = $urandom_range(20, 100);
            return 0;
        end
        if (r < 55) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [7:0] frame_char();
        string alphabet = "/STARTDAENOCIPG ";
        if ($urandom_range(0, 99) < 45) return 8'($urandom_range(0, 255));
        return alphabet[$urandom_range(0, alphabet.len() - 1)];
    endfunction

    function automatic void add_row(logic [7:0] b, bit typed, afd_pkg::t_result res);
        t_row row;
        row.rx_byte = b;
        row.typed   = typed;
        row.res     = res;
        directed_rows.push_back(row);
    endfunction

    function automatic void add_text_rows(string s);
        for (int i = 0; i < s.len(); i++) add_row(s[i], 1'b0, NO_EVENT);
    endfunction

    task automatic report_error(string msg);
        err_count++;
        if (err_count <= 10) $display("%0t: %s", $time, msg);
    endtask

    // Valid stays high after a request so back-to-back bytes need no toggle.
    task automatic send_byte(logic [7:0] b, bit typed, afd_pkg::t_result typed_res);
        int gap;
        afd_pkg::t_result predicted;
        gap = pick_gap(rx_calm);
        @(negedge i_clk);
        if (gap > 0) begin
            rx_if.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        rx_if.valid   <= 1'b1;
        rx_if.rx_byte <= b;
        do @(posedge i_clk); while (rx_if.ready !== 1'b1);
        predicted = frame_step(b);
        pending_results.push_back(typed ? typed_res : predicted);
        bytes_sent++;
    endtask

    task automatic drain_results();
        @(negedge i_clk);
        rx_if.valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    task automatic send_text(string s);
        for (int i = 0; i < s.len(); i++) send_byte(s[i], 1'b0, NO_EVENT);
    endtask

    task automatic send_body(int n);
        repeat (n) begin
            if ($urandom_range(0, 99) < 4) begin
                if ($urandom_range(0, 1)) send_text(starters[$urandom_range(0, 2)]);
                else send_text(enders[$urandom_range(0, 1)]);
            end else begin
                send_byte(frame_char(), 1'b0, NO_EVENT);
            end
        end
    endtask

    task automatic send_broken();
        string s;
        int    pos;
        if ($urandom_range(0, 1)) s = starters[$urandom_range(0, 2)];
        else s = enders[$urandom_range(0, 1)];
        if ($urandom_range(0, 1)) begin
            s = s.substr(0, $urandom_range(0, s.len() - 2));
        end else begin
            pos = $urandom_range(0, s.len() - 1);
            s[pos] = frame_char();
        end
        send_text(s);
    endtask

    task automatic send_frame(bit force_drop);
        int r;
        if ($urandom_range(0, 3) == 0) send_body($urandom_range(1, 12));
        send_text(starters[$urandom_range(0, 2)]);
        if (force_drop) begin
            // plain random bytes, long enough to run past the buffer
            repeat (BUF_BYTES) send_byte(8'($urandom_range(0, 255)), 1'b0, NO_EVENT);
        end else begin
            r = $urandom_range(0, 99);
            if (r < 15) send_body($urandom_range(0, 8));
            else if (r < 92) send_body($urandom_range(9, 40));
            else send_body($urandom_range(80, 235));
            send_text(enders[$urandom_range(0, 1)]);
        end
        // an end marker seen too early leaves the frame open
        while (in_frame) begin
            send_body($urandom_range(0, 15));
            send_text(enders[$urandom_range(0, 1)]);
        end
    endtask

    always @(negedge i_clk) begin
        if (res_stall > 0) begin
            res_if.ready <= 1'b0;
            res_stall <= res_stall - 1;
        end else begin
            res_if.ready <= 1'b1;
            res_stall <= pick_gap(res_calm);
        end
    end

    always @(posedge i_clk) begin : check_results
        afd_pkg::t_result want;
        if (i_rst_n && res_if.valid === 1'b1 && res_if.ready === 1'b1) begin
            if (pending_results.size() == 0) begin
                report_error($sformatf("unexpected result: event %0d length %0d",
                                       res_if.event_res, res_if.frame_length));
            end else begin
                want = pending_results.pop_front();
                if (res_if.event_res !== want.event_res) begin
                    report_error($sformatf("event_res expected %0d got %0d",
                                           want.event_res, res_if.event_res));
                end
                if (res_if.frame_length !== want.frame_length) begin
                    report_error($sformatf("frame_length expected %0d got %0d",
                                           want.frame_length, res_if.frame_length));
                end
            end
        end
    end

    initial begin
        #TIMEOUT;
        $display("ascii_frame_delimiter verification failed");
        $finish;
    end

    initial begin
        int seq_no;
        int kind;
        rx_if.valid   = 1'b0;
        rx_if.rx_byte = 8'h00;
        res_if.ready  = 1'b0;

        // extremes, native frame of minimum length, then a foreign start
        // in a window that is not yet full
        add_row(8'h00, 1'b1, NO_EVENT);
        add_row(8'hFF, 1'b1, NO_EVENT);
        add_text_rows("/STARTDATA");
        add_row("/", 1'b1, afd_pkg::t_result'{afd_pkg::EV_NATIVE_START, 8'd0});
        add_text_rows("/ENDDATA");
        add_row("/", 1'b1, afd_pkg::t_result'{afd_pkg::EV_DATA_END, 8'd20});
        add_text_rows("PING");
        add_row("/", 1'b1, afd_pkg::t_result'{afd_pkg::EV_FOREIGN_START, 8'd0});

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[i]) begin
            send_byte(directed_rows[i].rx_byte, directed_rows[i].typed, directed_rows[i].res);
        end
        drain_results();

        seq_no = 0;
        bytes_sent = 0;
        while (bytes_sent < RANDOM_ITEMS) begin
            kind = $urandom_range(0, 99);
            if (seq_no == 10) drain_results();
            if (seq_no == 2 || kind < 3) send_frame(1'b1);
            else if (kind < 12) send_body($urandom_range(1, 15));
            else if (kind < 20) send_broken();
            else send_frame(1'b0);
            seq_no++;
        end

        drain_results();
        repeat (8) @(posedge i_clk);
        if (err_count == 0) begin
            $display("ascii_frame_delimiter verification clean");
        end else begin
            $display("ascii_frame_delimiter verification failed");
        end
        $finish;
    end

endmodule

### filelist.f
design/afd_pkg.sv
design/afd_if.sv
design/afd_in_stage.sv
design/afd_tracker.sv
design/afd_out_stage.sv
design/ascii_frame_delimiter.sv
sim/tb_top.sv
